// File: sv/pixel_format_converter_defines.svh
// Assertion macros for the pixel format converter.
// Included by the files that carry concurrent assertions; no dependencies.
`ifndef PIXEL_FORMAT_CONVERTER_DEFINES_SVH
`define PIXEL_FORMAT_CONVERTER_DEFINES_SVH

`ifndef SYNTH
// checked only outside reset
`define PFC_ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pixel format converter assertion failed");
// checked through reset as well
`define PFC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("pixel format converter assertion failed");
`else
`define PFC_ASSERT_CLK(lbl, clk, rst, prop)
`define PFC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: sv/pfc_pkg.sv
// Package for the pixel format converter: format codes, register indexes,
// field widths and the configuration struct. No dependencies.
package pfc_pkg;

   localparam int PIXEL_W = 32;
   localparam int FMT_W   = 3;
   localparam int INDEX_W = 1;

   localparam logic [FMT_W-1:0] FMT_ARGB8888    = 3'd0;
   localparam logic [FMT_W-1:0] FMT_ARGB8888_PM = 3'd1;
   localparam logic [FMT_W-1:0] FMT_ARGB1555    = 3'd2;
   localparam logic [FMT_W-1:0] FMT_RGBA4444    = 3'd3;
   localparam logic [FMT_W-1:0] FMT_RGBA4444_PM = 3'd4;
   localparam logic [FMT_W-1:0] FMT_RGB565      = 3'd5;
   localparam logic [FMT_W-1:0] FMT_RGB888      = 3'd6;
   localparam logic [FMT_W-1:0] FMT_LAST        = FMT_RGB888;

   localparam logic [INDEX_W-1:0] REG_SOURCE_FORMAT = 1'b0;
   localparam logic [INDEX_W-1:0] REG_TARGET_FORMAT = 1'b1;

   typedef struct packed {
      logic [FMT_W-1:0] source_format;
      logic [FMT_W-1:0] target_format;
   } cfg_type;

endpackage

// File: sv/pfc_if.sv
// Valid/ready channel interfaces for pixel beats in and converted beats out.
// Depends on pfc_pkg for the pixel width.
interface pfc_req_if;
   logic                         valid;
   logic                         ready;
   logic [pfc_pkg::PIXEL_W-1:0]  pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface pfc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pfc_pkg::PIXEL_W-1:0]  pixel_out;
   logic                         unsupported;

   modport source (output valid, output pixel_out, output unsupported, input ready);
   modport sink   (input valid, input pixel_out, input unsupported, output ready);
endinterface

// File: sv/pfc_csr.sv
// Configuration registers: source and target format.
// Depends on pfc_pkg for register indexes and the config struct.
module pfc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [pfc_pkg::INDEX_W-1:0]   csr_index,
   input  logic [pfc_pkg::FMT_W-1:0]     csr_wdata,
   output pfc_pkg::cfg_type              cfg
);

   pfc_pkg::cfg_type cfg_ff;
   pfc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            pfc_pkg::REG_SOURCE_FORMAT: cfg_in.source_format = csr_wdata;
            pfc_pkg::REG_TARGET_FORMAT: cfg_in.target_format = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/pfc_convert.sv
// Combinational pixel conversion between the configured formats.
// Depends on pfc_pkg for format codes and the config struct.
module pfc_convert (
   input  pfc_pkg::cfg_type               cfg,
   input  logic [pfc_pkg::PIXEL_W-1:0]    pixel_in,
   output logic [pfc_pkg::PIXEL_W-1:0]    pixel_out,
   output logic                           unsupported
);

   logic [pfc_pkg::FMT_W-1:0]   src;
   logic [pfc_pkg::FMT_W-1:0]   tgt;
   logic [pfc_pkg::PIXEL_W-1:0] masked;
   logic [pfc_pkg::PIXEL_W-1:0] wide;
   logic [4:0]                  r5;
   logic [4:0]                  g5;
   logic [4:0]                  b5;
   logic [7:0]                  a;
   logic [7:0]                  r;
   logic [7:0]                  g;
   logic [7:0]                  b;
   logic [15:0]                 ra;
   logic [15:0]                 ga;
   logic [15:0]                 ba;
   logic [pfc_pkg::PIXEL_W-1:0] conv;
   logic                        conv_ok;

   assign src = cfg.source_format;
   assign tgt = cfg.target_format;

   always_comb begin
      unique case (src)
         pfc_pkg::FMT_ARGB1555, pfc_pkg::FMT_RGBA4444,
         pfc_pkg::FMT_RGBA4444_PM, pfc_pkg::FMT_RGB565:
            masked = {16'h0000, pixel_in[15:0]};
         pfc_pkg::FMT_RGB888:
            masked = {8'h00, pixel_in[23:0]};
         default:
            masked = pixel_in;
      endcase
   end

   // 1555 source expands to 8888 by bit replication
   assign r5 = masked[14:10];
   assign g5 = masked[9:5];
   assign b5 = masked[4:0];
   assign wide = (src == pfc_pkg::FMT_ARGB1555) ?
      {b5, b5[4:2], g5, g5[4:2], r5, r5[4:2], {8{masked[15]}}} : masked;

   assign a  = wide[7:0];
   assign r  = wide[15:8];
   assign g  = wide[23:16];
   assign b  = wide[31:24];
   assign ra = r * a;
   assign ga = g * a;
   assign ba = b * a;

   always_comb begin
      conv_ok = 1'b1;
      unique case (tgt)
         pfc_pkg::FMT_ARGB8888:
            conv = wide;
         pfc_pkg::FMT_ARGB8888_PM:
            conv = {ba[15:8], ga[15:8], ra[15:8], a};
         pfc_pkg::FMT_ARGB1555:
            conv = {16'h0000, a[7], r[7:3], g[7:3], b[7:3]};
         pfc_pkg::FMT_RGBA4444:
            conv = {16'h0000, r[7:4], g[7:4], b[7:4], a[7:4]};
         pfc_pkg::FMT_RGBA4444_PM:
            conv = {16'h0000, ra[15:12], ga[15:12], ba[15:12], a[7:4]};
         pfc_pkg::FMT_RGB565:
            conv = {16'h0000, r[7:3], g[7:2], b[7:3]};
         default: begin
            conv    = '0;
            conv_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      pixel_out   = '0;
      unsupported = 1'b1;
      priority if (src > pfc_pkg::FMT_LAST || tgt > pfc_pkg::FMT_LAST) begin
         pixel_out   = '0;
         unsupported = 1'b1;
      end else if (src == tgt) begin
         pixel_out   = masked;
         unsupported = 1'b0;
      end else if (src == pfc_pkg::FMT_ARGB8888 || src == pfc_pkg::FMT_ARGB1555) begin
         pixel_out   = conv;
         unsupported = !conv_ok;
      end else begin
         pixel_out   = '0;
         unsupported = 1'b1;
      end
   end

endmodule

// File: sv/pixel_format_converter.sv
// Pixel format converter: input register, conversion logic, result register.
// Path: an accepted req beat is held in the input register, converted, and held in the result register as its rsp beat.
// Throughput: one pixel per cycle; the two register stages stall only under rsp backpressure.
// Reset: synchronous, active high; clears both stage valids and the formats to argb8888.
// Depends on pfc_pkg, pfc_if, pfc_csr, pfc_convert and the assertion macro header.
`include "pixel_format_converter_defines.svh"

module pixel_format_converter (
   input  logic                          clock,
   input  logic                          reset,
   pfc_req_if.sink                       req_chan,
   pfc_rsp_if.source                     rsp_chan,
   input  logic                          csr_wen,
   input  logic [pfc_pkg::INDEX_W-1:0]   csr_index,
   input  logic [pfc_pkg::FMT_W-1:0]     csr_wdata
);

   pfc_pkg::cfg_type              cfg;
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [pfc_pkg::PIXEL_W-1:0]   s1_pixel_ff;
   logic                          s2_valid_ff;
   logic                          s2_valid_in;
   logic [pfc_pkg::PIXEL_W-1:0]   s2_pixel_ff;
   logic                          s2_unsup_ff;
   logic [pfc_pkg::PIXEL_W-1:0]   conv_pixel;
   logic                          conv_unsup;
   logic                          s1_free;
   logic                          s2_free;
   logic                          req_fire;
   logic                          s1_fire;

   pfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pfc_convert u_convert (
      .cfg         (cfg),
      .pixel_in    (s1_pixel_ff),
      .pixel_out   (conv_pixel),
      .unsupported (conv_unsup)
   );

   assign s2_free  = !s2_valid_ff || rsp_chan.ready;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign req_fire = req_chan.valid && s1_free;
   assign s1_fire  = s1_valid_ff && s2_free;

   assign s1_valid_in = s1_free ? req_chan.valid : s1_valid_ff;
   assign s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pixel_ff <= req_chan.pixel_in;
      end
      if (s1_fire) begin
         s2_pixel_ff <= conv_pixel;
         s2_unsup_ff <= conv_unsup;
      end
   end

   assign req_chan.ready       = s1_free;
   assign rsp_chan.valid       = s2_valid_ff;
   assign rsp_chan.pixel_out   = s2_pixel_ff;
   assign rsp_chan.unsupported = s2_unsup_ff;

   `PFC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !s1_valid_ff && !s2_valid_ff)
   `PFC_ASSERT_CLK(a_req_lands, clock, reset, req_fire |=> s1_valid_ff)
   `PFC_ASSERT_CLK(a_stage_moves, clock, reset, s1_fire |=> rsp_chan.valid)
   `PFC_ASSERT_CLK(a_unsup_zero, clock, reset,
      (rsp_chan.valid && rsp_chan.unsupported) |-> (rsp_chan.pixel_out == '0))

endmodule
